/* src/acbpix_pkg.sv */
// ----------------------------------------------------------------------------
// acbpix_pkg
// Shared widths, defaults and the gamma table of the checkerboard pixel core.
// ----------------------------------------------------------------------------
`default_nettype none

package acbpix_pkg;

    // Field widths fixed by the pixel and register formats.
    localparam int COORD_W          = 12;
    localparam int GRAY_W           = 8;
    localparam int IMAGE_SIDE_W     = 13;
    localparam int IMAGE_SIDE_RESET = 256;

    // Defaults for the top-level parameters.
    localparam int MAX_SIDE_DEFAULT       = 4096;
    localparam int CELLS_PER_SIDE_DEFAULT = 8;

    // Depth of the queue between the classifier and the shading pipeline.
    localparam int QUEUE_DEPTH = 4;

    // Configuration bus.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    // Blend index runs over 0..64 in steps of 1/64.
    localparam int T_W    = 7;
    localparam int T_FULL = 64;

    // floor(255 * (t/64)^(1/2.2)) for t = 0..64.
    localparam logic [GRAY_W-1:0] GAMMA_TAB [T_FULL+1] = '{
        8'd0,   8'd38,  8'd52,  8'd63,  8'd72,  8'd80,  8'd86,  8'd93,
        8'd99,  8'd104, 8'd109, 8'd114, 8'd119, 8'd123, 8'd127, 8'd131,
        8'd135, 8'd139, 8'd143, 8'd146, 8'd150, 8'd153, 8'd156, 8'd160,
        8'd163, 8'd166, 8'd169, 8'd172, 8'd175, 8'd177, 8'd180, 8'd183,
        8'd186, 8'd188, 8'd191, 8'd193, 8'd196, 8'd198, 8'd201, 8'd203,
        8'd205, 8'd208, 8'd210, 8'd212, 8'd215, 8'd217, 8'd219, 8'd221,
        8'd223, 8'd225, 8'd227, 8'd229, 8'd232, 8'd234, 8'd236, 8'd238,
        8'd239, 8'd241, 8'd243, 8'd245, 8'd247, 8'd249, 8'd251, 8'd253,
        8'd255
    };

    function automatic logic [GRAY_W-1:0] gamma_lookup(input logic [T_W-1:0] t);
        logic [GRAY_W-1:0] g;
        if (t > T_W'(T_FULL)) begin
            g = GAMMA_TAB[T_FULL];
        end else begin
            g = GAMMA_TAB[t];
        end
        return g;
    endfunction

endpackage

`default_nettype wire

/* src/acbpix_pix_if.sv */
// ----------------------------------------------------------------------------
// acbpix_pix_if
// Pixel coordinate request channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface acbpix_pix_if;
    logic                             valid;
    logic                             ready;
    logic [acbpix_pkg::COORD_W-1:0]   pixel_row;
    logic [acbpix_pkg::COORD_W-1:0]   pixel_col;

    modport source (output valid, output pixel_row, output pixel_col, input ready);
    modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

`default_nettype wire

/* src/acbpix_gray_if.sv */
// ----------------------------------------------------------------------------
// acbpix_gray_if
// Gray level result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface acbpix_gray_if;
    logic                            valid;
    logic                            ready;
    logic [acbpix_pkg::GRAY_W-1:0]   gray_level;
    logic                            out_of_range;

    modport source (output valid, output gray_level, output out_of_range, input ready);
    modport sink   (input valid, input gray_level, input out_of_range, output ready);
endinterface

`default_nettype wire

/* src/antialiased_checkerboard_pixel_core.sv */
// ----------------------------------------------------------------------------
// antialiased_checkerboard_pixel_core
// Antialiased checkerboard test pattern: pixel coordinate in, gray level out.
// ----------------------------------------------------------------------------
// For each request of a pixel row and column the core returns the gray level
// of a CELLS_PER_SIDE by CELLS_PER_SIDE checkerboard laid over a square image
// whose side is set through the APB register at any byte address (13 bits,
// reset 256, clamped to MAX_SIDE). Cells whose indices sum to an even number
// are black. Edge pixels are blended by their exact coverage in 1/N pixel
// steps and shaped by a 1/2.2 gamma table. Pixels at or beyond the side, or
// any pixel when the side is zero, come back with out_of_range set and a gray
// level of zero. The core takes one request every clock while the queue is
// not full and returns one result for every request, in order. A request
// is written into the queue at the edge that accepts it and leaves it for
// the first of four pipeline stages (coverage, blend weight, scaling, gamma
// lookup); the last stage is the output register. A four-entry queue
// between the cell classifier and the shading pipeline lets the request side
// keep going while the result side is stalled, until the queue fills.
// Writing the side register also recomputes the cell boundaries in the same
// clock, so requests may follow right after the write completes; the
// register should only be written while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module antialiased_checkerboard_pixel_core #(
    parameter int MAX_SIDE       = acbpix_pkg::MAX_SIDE_DEFAULT,
    parameter int CELLS_PER_SIDE = acbpix_pkg::CELLS_PER_SIDE_DEFAULT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [acbpix_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [acbpix_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [acbpix_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                    pready,
    // Pixel requests in, gray levels out.
    acbpix_pix_if.sink                              i_pix,
    acbpix_gray_if.source                           o_gray
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int BND_W  = $clog2(CELLS_PER_SIDE * MAX_SIDE + 1);
    localparam int IDX_W  = $clog2(CELLS_PER_SIDE);
    localparam int NC_W   = acbpix_pkg::COORD_W + $clog2(CELLS_PER_SIDE);
    localparam int ENT_W  = 2 * IDX_W + 2 * NC_W + 1;

    // Clamped side and the boundaries (j+1)*side, j = 0..N-1, in 1/N pixel.
    logic [SIDE_W-1:0]                     w_side;
    logic [CELLS_PER_SIDE-1:0][BND_W-1:0]  w_bound;

    // Classified requests travelling from the front end to the shader.
    logic             w_push, w_full, w_pop, w_qvalid;
    logic [ENT_W-1:0] w_push_entry, w_pop_entry;

    acbpix_cfg #(
        .MAX_SIDE       (MAX_SIDE),
        .CELLS_PER_SIDE (CELLS_PER_SIDE)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_side  (w_side),
        .o_bound (w_bound)
    );

    // Front end: finds each axis' cell by comparing against the boundaries
    // and flags coordinates outside the image.
    acbpix_front #(
        .MAX_SIDE       (MAX_SIDE),
        .CELLS_PER_SIDE (CELLS_PER_SIDE)
    ) u_front (
        .i_pix   (i_pix),
        .i_side  (w_side),
        .i_bound (w_bound),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    acbpix_queue #(
        .WIDTH (ENT_W),
        .DEPTH (acbpix_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_data  (w_pop_entry)
    );

    // Back end: coverage, blend weight, scaling to 1/64 and gamma lookup.
    acbpix_back #(
        .MAX_SIDE       (MAX_SIDE),
        .CELLS_PER_SIDE (CELLS_PER_SIDE)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bound (w_bound),
        .i_valid (w_qvalid),
        .i_entry (w_pop_entry),
        .o_pop   (w_pop),
        .o_gray  (o_gray)
    );

endmodule

`default_nettype wire

/* src/acbpix_cfg.sv */
// ----------------------------------------------------------------------------
// acbpix_cfg
// Image side register on the APB port and the precomputed cell boundaries.
// ----------------------------------------------------------------------------
`default_nettype none

module acbpix_cfg #(
    parameter int MAX_SIDE       = acbpix_pkg::MAX_SIDE_DEFAULT,
    parameter int CELLS_PER_SIDE = acbpix_pkg::CELLS_PER_SIDE_DEFAULT,
    localparam int SIDE_W        = $clog2(MAX_SIDE + 1),
    localparam int BND_W         = $clog2(CELLS_PER_SIDE * MAX_SIDE + 1)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [acbpix_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [acbpix_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [acbpix_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                    pready,
    output logic      [SIDE_W-1:0]                  o_side,
    output logic      [CELLS_PER_SIDE-1:0][BND_W-1:0] o_bound
);

    localparam int CMP_W = (SIDE_W > acbpix_pkg::IMAGE_SIDE_W) ?
                           SIDE_W : acbpix_pkg::IMAGE_SIDE_W;

    logic [acbpix_pkg::IMAGE_SIDE_W-1:0]   r_image_side, n_image_side;
    logic [SIDE_W-1:0]                     r_side, n_side;
    logic [CELLS_PER_SIDE-1:0][BND_W-1:0]  r_bound, n_bound;
    logic                                  w_write;

    function automatic logic [SIDE_W-1:0] clamp_side(
        input logic [acbpix_pkg::IMAGE_SIDE_W-1:0] v
    );
        logic [SIDE_W-1:0] c;
        if (CMP_W'(v) > CMP_W'(MAX_SIDE)) begin
            c = SIDE_W'(MAX_SIDE);
        end else begin
            c = SIDE_W'(v);
        end
        return c;
    endfunction

    // The register is the only one, so every address decodes to it.
    assign w_write = psel & penable & pwrite & (paddr == paddr);

    always_comb begin
        n_image_side = r_image_side;
        if (w_write) begin
            n_image_side = pwdata[acbpix_pkg::IMAGE_SIDE_W-1:0];
        end
        n_side = clamp_side(n_image_side);
        // Boundary j sits at (j+1) * side in units of 1/N pixel.
        for (int j = 0; j < CELLS_PER_SIDE; j++) begin
            n_bound[j] = BND_W'(j + 1) * BND_W'(n_side);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_side <= acbpix_pkg::IMAGE_SIDE_W'(acbpix_pkg::IMAGE_SIDE_RESET);
            r_side       <= clamp_side(
                acbpix_pkg::IMAGE_SIDE_W'(acbpix_pkg::IMAGE_SIDE_RESET));
            for (int j = 0; j < CELLS_PER_SIDE; j++) begin
                r_bound[j] <= BND_W'(j + 1) * BND_W'(clamp_side(
                    acbpix_pkg::IMAGE_SIDE_W'(acbpix_pkg::IMAGE_SIDE_RESET)));
            end
        end else begin
            r_image_side <= n_image_side;
            r_side       <= n_side;
            r_bound      <= n_bound;
        end
    end

    assign prdata  = acbpix_pkg::APB_DATA_W'(r_image_side);
    assign pready  = 1'b1;
    assign o_side  = r_side;
    assign o_bound = r_bound;

endmodule

`default_nettype wire

/* src/acbpix_front.sv */
// ----------------------------------------------------------------------------
// acbpix_front
// Accepts pixel requests, finds the cell of each axis and the range flag.
// ----------------------------------------------------------------------------
`default_nettype none

module acbpix_front #(
    parameter int MAX_SIDE       = acbpix_pkg::MAX_SIDE_DEFAULT,
    parameter int CELLS_PER_SIDE = acbpix_pkg::CELLS_PER_SIDE_DEFAULT,
    localparam int SIDE_W        = $clog2(MAX_SIDE + 1),
    localparam int BND_W         = $clog2(CELLS_PER_SIDE * MAX_SIDE + 1),
    localparam int IDX_W         = $clog2(CELLS_PER_SIDE),
    localparam int NC_W          = acbpix_pkg::COORD_W + $clog2(CELLS_PER_SIDE),
    localparam int ENT_W         = 2 * IDX_W + 2 * NC_W + 1
) (
    acbpix_pix_if.sink                           i_pix,
    input  wire logic [SIDE_W-1:0]               i_side,
    input  wire logic [CELLS_PER_SIDE-1:0][BND_W-1:0] i_bound,
    input  wire logic                            i_full,
    output logic                                 o_push,
    output logic      [ENT_W-1:0]                o_entry
);

    localparam int CW = (NC_W > BND_W) ? NC_W : BND_W;
    localparam int XW = (SIDE_W > acbpix_pkg::COORD_W) ? SIDE_W : acbpix_pkg::COORD_W;

    logic [NC_W-1:0]  w_nrow, w_ncol;
    logic [IDX_W-1:0] w_idx_r, w_idx_c;
    logic             w_oor;

    assign w_nrow = NC_W'(i_pix.pixel_row) * NC_W'(CELLS_PER_SIDE);
    assign w_ncol = NC_W'(i_pix.pixel_col) * NC_W'(CELLS_PER_SIDE);

    // The boundaries rise monotonically, so counting the ones passed gives
    // the cell index.
    always_comb begin
        w_idx_r = '0;
        w_idx_c = '0;
        for (int k = 0; k < CELLS_PER_SIDE - 1; k++) begin
            if (CW'(w_nrow) >= CW'(i_bound[k])) begin
                w_idx_r = w_idx_r + IDX_W'(1);
            end
            if (CW'(w_ncol) >= CW'(i_bound[k])) begin
                w_idx_c = w_idx_c + IDX_W'(1);
            end
        end
    end

    assign w_oor = (i_side == '0) ||
                   (XW'(i_pix.pixel_row) >= XW'(i_side)) ||
                   (XW'(i_pix.pixel_col) >= XW'(i_side));

    assign i_pix.ready = ~i_full;
    assign o_push      = i_pix.valid & ~i_full;
    assign o_entry     = {w_oor, w_idx_r, w_idx_c, w_nrow, w_ncol};

endmodule

`default_nettype wire

/* src/acbpix_queue.sv */
// ----------------------------------------------------------------------------
// acbpix_queue
// Small first-in first-out buffer between the classifier and the shader.
// ----------------------------------------------------------------------------
`default_nettype none

module acbpix_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = acbpix_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        n_count = r_count + CNT_W'(w_do_push) - CNT_W'(w_do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

/* src/acbpix_back.sv */
// ----------------------------------------------------------------------------
// acbpix_back
// Four-stage shading pipeline: coverage, blend weight, scaling, gamma lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module acbpix_back #(
    parameter int MAX_SIDE       = acbpix_pkg::MAX_SIDE_DEFAULT,
    parameter int CELLS_PER_SIDE = acbpix_pkg::CELLS_PER_SIDE_DEFAULT,
    localparam int BND_W         = $clog2(CELLS_PER_SIDE * MAX_SIDE + 1),
    localparam int IDX_W         = $clog2(CELLS_PER_SIDE),
    localparam int NC_W          = acbpix_pkg::COORD_W + $clog2(CELLS_PER_SIDE),
    localparam int ENT_W         = 2 * IDX_W + 2 * NC_W + 1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [CELLS_PER_SIDE-1:0][BND_W-1:0] i_bound,
    input  wire logic                            i_valid,
    input  wire logic [ENT_W-1:0]                i_entry,
    output logic                                 o_pop,
    acbpix_gray_if.source                        o_gray
);

    localparam int N     = CELLS_PER_SIDE;
    localparam int CW    = (NC_W > BND_W) ? NC_W : BND_W;
    localparam int Q_W   = $clog2(N + 1);
    localparam int D     = N * N;
    localparam int S_W   = $clog2(D + 1);
    // Reciprocal of D scaled by 64; the estimate is at most one low.
    localparam int SH    = S_W;
    localparam int M     = ((1 << SH) * acbpix_pkg::T_FULL) / D;
    localparam int M_W   = $clog2(M + 1);
    localparam int P_W   = S_W + M_W;
    localparam int T_W   = acbpix_pkg::T_W;
    localparam int E_W   = T_W + S_W + 1;

    // Queue entry fields.
    logic             w_oor;
    logic [IDX_W-1:0] w_idx_r, w_idx_c;
    logic [NC_W-1:0]  w_nrow, w_ncol;
    logic [CW-1:0]    w_diff_r, w_diff_c;

    // Stage registers.
    logic             r_v1, r_v2, r_v3, r_v4;
    logic             r_oor1, r_oor2, r_oor3;
    logic             r_flip1, r_flip2, r_flip3;
    logic [Q_W-1:0]   r_qr, r_qc;
    logic [S_W-1:0]   r_s2, r_s3;
    logic [T_W-1:0]   r_t0;
    logic [acbpix_pkg::GRAY_W-1:0] r_gray;
    logic             r_oor4;

    logic             w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic [S_W-1:0]   w_s;
    logic [P_W-1:0]   w_prod;
    logic [T_W-1:0]   w_t, w_tsel;

    assign {w_oor, w_idx_r, w_idx_c, w_nrow, w_ncol} = i_entry;

    // A stage takes a new item when it is empty or its content moves on.
    assign w_rdy4 = ~r_v4 | o_gray.ready;
    assign w_rdy3 = ~r_v3 | w_rdy4;
    assign w_rdy2 = ~r_v2 | w_rdy3;
    assign w_rdy1 = ~r_v1 | w_rdy2;
    assign o_pop  = i_valid & w_rdy1;

    // Coverage in 1/N pixel: distance to the next boundary, at most N.
    assign w_diff_r = CW'(i_bound[w_idx_r]) - CW'(w_nrow);
    assign w_diff_c = CW'(i_bound[w_idx_c]) - CW'(w_ncol);

    assign w_s = S_W'(r_qr) * S_W'(r_qc) +
                 S_W'(Q_W'(N) - r_qr) * S_W'(Q_W'(N) - r_qc);

    assign w_prod = P_W'(r_s2) * P_W'(M);

    always_comb begin
        w_t = r_t0;
        if (E_W'(r_t0 + T_W'(1)) * E_W'(D) <= E_W'(r_s3) * E_W'(acbpix_pkg::T_FULL)) begin
            w_t = r_t0 + T_W'(1);
        end
        if (w_t > T_W'(acbpix_pkg::T_FULL)) begin
            w_t = T_W'(acbpix_pkg::T_FULL);
        end
        // Black cells read the table from the other end.
        w_tsel = r_flip3 ? T_W'(acbpix_pkg::T_FULL) - w_t : w_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_oor1  <= w_oor;
            r_flip1 <= ~(w_idx_r[0] ^ w_idx_c[0]);
            r_qr    <= (w_diff_r > CW'(N)) ? Q_W'(N) : w_diff_r[Q_W-1:0];
            r_qc    <= (w_diff_c > CW'(N)) ? Q_W'(N) : w_diff_c[Q_W-1:0];
        end
        if (w_rdy2) begin
            r_oor2  <= r_oor1;
            r_flip2 <= r_flip1;
            r_s2    <= w_s;
        end
        if (w_rdy3) begin
            r_oor3  <= r_oor2;
            r_flip3 <= r_flip2;
            r_s3    <= r_s2;
            r_t0    <= w_prod[SH +: T_W];
        end
        if (w_rdy4) begin
            r_oor4  <= r_oor3;
            r_gray  <= r_oor3 ? '0 : acbpix_pkg::gamma_lookup(w_tsel);
        end
    end

    assign o_gray.valid        = r_v4;
    assign o_gray.gray_level   = r_gray;
    assign o_gray.out_of_range = r_oor4;

endmodule

`default_nettype wire
